// ===== rtl/core/cle_pkg.sv =====
package cle_pkg;

    // Event codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_TIMEOUT   = 2'd0,
        OP_REQUEST   = 2'd1,
        OP_RESPONSE  = 2'd2,
        OP_GET_STATE = 2'd3
    } op_t;

    // Node role, also reported on the result.
    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SERVER_ID      = 2'd0,
        CFG_CLUSTER_SIZE   = 2'd1,
        CFG_OWN_LAST_TERM  = 2'd2,
        CFG_OWN_LAST_INDEX = 2'd3
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned MSG_TERM_W  = 32;
    localparam int unsigned IN_TDATA_W  = 136;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [4:0] NO_VOTE       = 5'd16;
    localparam logic [4:0] VOTES_MAX     = 5'd31;
    localparam logic [4:0] CLUSTER_RESET = 5'd3;

    typedef struct packed {
        logic [3:0]  server_id;
        logic [4:0]  cluster_size;
        logic [31:0] own_last_log_term;
        logic [31:0] own_last_log_index;
    } cfg_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] msg_term;
        logic [3:0]  candidate_id;
        logic [31:0] cand_last_log_term;
        logic [31:0] cand_last_log_index;
        logic [31:0] election_term;
        logic        vote_yes;
    } event_t;

    typedef struct packed {
        logic [31:0] term_now;
        logic        vote_granted;
        logic        is_leader;
        role_t       role_now;
        logic        send_vote_requests;
        logic        restart_timer;
    } result_t;

endpackage

// ===== rtl/core/cle_event_reg.sv =====
// Input register stage: holds one event until the election stage takes it.
module cle_event_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cle_pkg::event_t in_event,
    output logic            ev_valid,
    input  logic            ev_take,
    output cle_pkg::event_t ev_event
);

    logic            valid_reg;
    logic            valid_next;
    cle_pkg::event_t event_reg;

    assign in_ready   = !valid_reg || ev_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !ev_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            event_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev_event = event_reg;

endmodule

// ===== rtl/core/cle_elect.sv =====
// Election state and result register. One event is applied per cycle while the result register is not stalled.
module cle_elect
#(
    parameter int unsigned MAX_NODES = 16,
    parameter int unsigned TERM_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cle_pkg::cfg_t    cfg,
    input  logic             ev_valid,
    output logic             ev_take,
    input  cle_pkg::event_t  ev_event,
    output logic             res_valid,
    input  logic             res_ready,
    output cle_pkg::result_t res
);

    localparam int unsigned CW = (TERM_BITS > cle_pkg::MSG_TERM_W) ?
                                 TERM_BITS : cle_pkg::MSG_TERM_W;
    localparam int unsigned SW0 = $clog2(MAX_NODES + 1);
    localparam int unsigned SW  = (SW0 > 5) ? SW0 : 5;
    localparam logic [TERM_BITS-1:0] TERM_MAX = {TERM_BITS{1'b1}};

    cle_pkg::role_t         role_reg;
    cle_pkg::role_t         role_next;
    logic [TERM_BITS-1:0]   term_reg;
    logic [TERM_BITS-1:0]   term_next;
    logic [4:0]             vf_reg;
    logic [4:0]             vf_next;
    logic [4:0]             votes_reg;
    logic [4:0]             votes_next;
    logic                   out_valid_reg;
    cle_pkg::result_t       res_reg;
    cle_pkg::result_t       res_next;

    logic [SW-1:0]          size_raw;
    logic [SW-1:0]          size_eff;
    logic [SW-1:0]          half;
    logic [CW-1:0]          mterm_wide;
    logic [CW-1:0]          term_wide;
    logic [TERM_BITS-1:0]   mterm;
    logic                   log_ok;
    logic                   eterm_match;
    logic [4:0]             votes_inc;
    logic                   granted;
    logic                   send;
    logic                   restart;

    assign ev_take = ev_valid && (!out_valid_reg || res_ready);

    // Majority threshold from the clamped cluster size.
    assign size_raw = SW'(cfg.cluster_size);
    assign size_eff = (size_raw == '0) ? SW'(1) :
                      (size_raw > SW'(MAX_NODES)) ? SW'(MAX_NODES) : size_raw;
    assign half     = size_eff >> 1;

    assign mterm_wide  = CW'(ev_event.msg_term);
    assign mterm       = mterm_wide[TERM_BITS-1:0];
    assign eterm_match = (CW'(term_reg) == CW'(ev_event.election_term));
    assign log_ok      = (ev_event.cand_last_log_term > cfg.own_last_log_term) ||
                         ((ev_event.cand_last_log_term == cfg.own_last_log_term) &&
                          (ev_event.cand_last_log_index >= cfg.own_last_log_index));
    assign votes_inc   = (ev_event.vote_yes && (votes_reg != cle_pkg::VOTES_MAX)) ?
                         votes_reg + 5'd1 : votes_reg;

    always_comb
    begin
        role_next  = role_reg;
        term_next  = term_reg;
        vf_next    = vf_reg;
        votes_next = votes_reg;
        granted    = 1'b0;
        send       = 1'b0;
        restart    = 1'b0;
        case (ev_event.operation)
            cle_pkg::OP_TIMEOUT:
            begin
                if (role_reg != cle_pkg::ROLE_LEADER)
                begin
                    if (term_reg != TERM_MAX)
                    begin
                        term_next = term_reg + 1'b1;
                    end
                    role_next  = cle_pkg::ROLE_CANDIDATE;
                    vf_next    = {1'b0, cfg.server_id};
                    votes_next = 5'd1;
                    send       = 1'b1;
                    restart    = 1'b1;
                    // The self vote alone wins in a one-node cluster.
                    if (half == '0)
                    begin
                        role_next = cle_pkg::ROLE_LEADER;
                    end
                end
            end
            cle_pkg::OP_REQUEST:
            begin
                if (mterm > term_reg)
                begin
                    role_next = cle_pkg::ROLE_FOLLOWER;
                    term_next = mterm;
                    vf_next   = cle_pkg::NO_VOTE;
                end
                if ((mterm == term_next) &&
                    ((vf_next == cle_pkg::NO_VOTE) ||
                     (vf_next == {1'b0, ev_event.candidate_id})) && log_ok)
                begin
                    granted   = 1'b1;
                    vf_next   = {1'b0, ev_event.candidate_id};
                    role_next = cle_pkg::ROLE_FOLLOWER;
                    restart   = 1'b1;
                end
            end
            cle_pkg::OP_RESPONSE:
            begin
                if (mterm > term_reg)
                begin
                    role_next = cle_pkg::ROLE_FOLLOWER;
                    term_next = mterm;
                    vf_next   = cle_pkg::NO_VOTE;
                end
                else if ((role_reg == cle_pkg::ROLE_CANDIDATE) && eterm_match)
                begin
                    votes_next = votes_inc;
                    if (SW'(votes_inc) > half)
                    begin
                        role_next = cle_pkg::ROLE_LEADER;
                        restart   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign term_wide = CW'(term_next);

    always_comb
    begin
        res_next.term_now           = term_wide[31:0];
        res_next.vote_granted       = granted;
        res_next.is_leader          = (role_next == cle_pkg::ROLE_LEADER);
        res_next.role_now           = role_next;
        res_next.send_vote_requests = send;
        res_next.restart_timer      = restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg      <= cle_pkg::ROLE_FOLLOWER;
            term_reg      <= '0;
            vf_reg        <= cle_pkg::NO_VOTE;
            votes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_take)
            begin
                role_reg  <= role_next;
                term_reg  <= term_next;
                vf_reg    <= vf_next;
                votes_reg <= votes_next;
            end
            if (ev_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/consensus_leader_election.sv =====
// Channel   Direction  Signals                                     Content
// s_        in         s_tvalid, s_tready, s_tdata, s_tuser        one election event
// m_        out        m_tvalid, m_tready, m_tdata                 one result per event
// cfg_      in         cfg_we, cfg_index, cfg_data                 register writes
//
// Every event produces exactly one result. An event is captured in the input
// register and is applied to the election state when the result register
// loads, which a stalled result delays. The block sustains one event per
// clock while the result side does not stall. The combinational state update
// (term compare, increment and vote count) sets that rate.
// Reset (rst_n, asynchronous, active low) makes the node a follower in term
// zero with no vote cast and loads the register defaults.
// A stalled result register holds its transfer; the input register still
// takes one more event before s_tready drops.
module consensus_leader_election
#(
    parameter int unsigned MAX_NODES = 16,
    parameter int unsigned TERM_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // msg_term[31:0], candidate_id[35:32], cand_last_log_term[67:36],
    // cand_last_log_index[99:68], election_term[131:100], vote_yes[132], zero pad
    input  logic [cle_pkg::IN_TDATA_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // term_now[31:0], vote_granted[32], is_leader[33], role_now[35:34],
    // send_vote_requests[36], restart_timer[37], zero pad
    output logic [cle_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [cle_pkg::CFG_DATA_W-1:0]      cfg_data
);

    cle_pkg::cfg_t    cfg_reg;
    cle_pkg::event_t  in_event;
    cle_pkg::event_t  ev_event;
    cle_pkg::result_t res;
    logic             ev_valid;
    logic             ev_take;

    // Configuration registers. A write lands at any edge with cfg_we high, so
    // writes belong in stretches where no event is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.server_id          <= '0;
            cfg_reg.cluster_size       <= cle_pkg::CLUSTER_RESET;
            cfg_reg.own_last_log_term  <= '0;
            cfg_reg.own_last_log_index <= '0;
        end
        else if (cfg_we)
        begin
            case (cle_pkg::cfg_idx_t'(cfg_index))
                cle_pkg::CFG_SERVER_ID:      cfg_reg.server_id          <= cfg_data[3:0];
                cle_pkg::CFG_CLUSTER_SIZE:   cfg_reg.cluster_size       <= cfg_data[4:0];
                cle_pkg::CFG_OWN_LAST_TERM:  cfg_reg.own_last_log_term  <= cfg_data;
                cle_pkg::CFG_OWN_LAST_INDEX: cfg_reg.own_last_log_index <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Unpack the incoming transfer; the pad bits above vote_yes are ignored.
    always_comb
    begin
        in_event.operation           = cle_pkg::op_t'(s_tuser);
        in_event.msg_term            = s_tdata[31:0];
        in_event.candidate_id        = s_tdata[35:32];
        in_event.cand_last_log_term  = s_tdata[67:36];
        in_event.cand_last_log_index = s_tdata[99:68];
        in_event.election_term       = s_tdata[131:100];
        in_event.vote_yes            = s_tdata[132];
    end

    cle_event_reg u_event_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_event (in_event),
        .ev_valid (ev_valid),
        .ev_take  (ev_take),
        .ev_event (ev_event)
    );

    cle_elect
    #(
        .MAX_NODES (MAX_NODES),
        .TERM_BITS (TERM_BITS)
    )
    u_elect
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev_take   (ev_take),
        .ev_event  (ev_event),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result, first field in the lowest bits.
    assign m_tdata = {2'b00,
                      res.restart_timer,
                      res.send_vote_requests,
                      res.role_now,
                      res.is_leader,
                      res.vote_granted,
                      res.term_now};

endmodule

// ===== bench/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int unsigned NODE_LIMIT = 16;

    // Mirror of the election state of one node. Every accepted event is
    // applied here in acceptance order, and the result it must produce is
    // queued until the matching transfer leaves the block.
    class election_tracker;

        role_t       role;
        logic [31:0] term;
        logic [4:0]  voted;
        logic [4:0]  votes;
        logic [3:0]  node_id;
        logic [4:0]  nodes;
        logic [31:0] log_term;
        logic [31:0] log_index;
        result_t     pending_results[$];
        int          errors;

        function new();
            role      = ROLE_FOLLOWER;
            term      = '0;
            voted     = NO_VOTE;
            votes     = '0;
            node_id   = '0;
            nodes     = CLUSTER_RESET;
            log_term  = '0;
            log_index = '0;
            errors    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_SERVER_ID:      node_id   = value[3:0];
                CFG_CLUSTER_SIZE:   nodes     = value[4:0];
                CFG_OWN_LAST_TERM:  log_term  = value;
                CFG_OWN_LAST_INDEX: log_index = value;
                default: ;
            endcase
        endfunction

        // A zero cluster counts as one node and anything above the node
        // limit counts as the limit.
        function bit has_majority();
            int unsigned n;
            n = (nodes == 5'd0) ? 1 :
                ((32'(nodes) > NODE_LIMIT) ? NODE_LIMIT : 32'(nodes));
            return 32'(votes) > n / 2;
        endfunction

        function void step_down(logic [31:0] new_term);
            role  = ROLE_FOLLOWER;
            term  = new_term;
            voted = NO_VOTE;
        endfunction

        function void note_event(event_t ev);
            result_t r;
            bit      log_ok;
            r      = '0;
            log_ok = (ev.cand_last_log_term > log_term) ||
                     (ev.cand_last_log_term == log_term &&
                      ev.cand_last_log_index >= log_index);
            case (ev.operation)
                OP_TIMEOUT:
                begin
                    if (role != ROLE_LEADER)
                    begin
                        if (term != '1)
                            term = term + 32'd1;
                        role  = ROLE_CANDIDATE;
                        voted = {1'b0, node_id};
                        votes = 5'd1;
                        r.send_vote_requests = 1'b1;
                        r.restart_timer      = 1'b1;
                        if (has_majority())
                            role = ROLE_LEADER;
                    end
                end
                OP_REQUEST:
                begin
                    if (ev.msg_term > term)
                        step_down(ev.msg_term);
                    if (ev.msg_term == term && log_ok &&
                        (voted == NO_VOTE || voted == {1'b0, ev.candidate_id}))
                    begin
                        r.vote_granted  = 1'b1;
                        r.restart_timer = 1'b1;
                        voted = {1'b0, ev.candidate_id};
                        role  = ROLE_FOLLOWER;
                    end
                end
                OP_RESPONSE:
                begin
                    if (ev.msg_term > term)
                        step_down(ev.msg_term);
                    else if (role == ROLE_CANDIDATE && term == ev.election_term)
                    begin
                        if (ev.vote_yes && votes < VOTES_MAX)
                            votes = votes + 5'd1;
                        if (has_majority())
                        begin
                            role            = ROLE_LEADER;
                            r.restart_timer = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.term_now  = term;
            r.is_leader = (role == ROLE_LEADER);
            r.role_now  = role;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t mismatch on %s: expected %0h actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare_field("term_now", e.term_now, d[31:0]);
            compare_field("vote_granted", 32'(e.vote_granted), 32'(d[32]));
            compare_field("is_leader", 32'(e.is_leader), 32'(d[33]));
            compare_field("role_now", 32'(e.role_now), 32'(d[35:34]));
            compare_field("send_vote_requests", 32'(e.send_vote_requests), 32'(d[36]));
            compare_field("restart_timer", 32'(e.restart_timer), 32'(d[37]));
            compare_field("padding", 32'd0, 32'(d[39:38]));
        endfunction

    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]             s_tuser   = OP_TIMEOUT;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [1:0]             cfg_index = CFG_SERVER_ID;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    election_tracker sb = new();

    // Chance in percent that a burst of idle cycles starts on the event side
    // and on the result side. Each phase picks its own, including zero, so
    // some stretches run at full rate.
    int gap_pct   = 15;
    int stall_pct = 15;

    consensus_leader_election u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Result side: random stall bursts. All signals used here are sampled
    // right after the edge, before any update of that edge lands, so the sampled
    // values are the ones the edge acted on.
    initial
    begin : ready_gen
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Offers one event, possibly after an idle burst, and returns at the edge
    // that accepts it. When no burst is taken, s_tvalid simply stays high so
    // back-to-back events go in on consecutive cycles while s_tready stays high.
    task automatic send_event(event_t ev);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.operation;
        s_tdata  <= {3'b000, ev.vote_yes, ev.election_term, ev.cand_last_log_index,
                     ev.cand_last_log_term, ev.candidate_id, ev.msg_term};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(ev);
    endtask

    task automatic post(op_t op, logic [31:0] mt, logic [3:0] cid, logic [31:0] lt,
                        logic [31:0] li, logic [31:0] et, logic yes);
        event_t ev;
        ev.operation           = op;
        ev.msg_term            = mt;
        ev.candidate_id        = cid;
        ev.cand_last_log_term  = lt;
        ev.cand_last_log_index = li;
        ev.election_term       = et;
        ev.vote_yes            = yes;
        send_event(ev);
    endtask

    // Stops offering events and waits until every queued result has left,
    // plus some margin.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges with the enable held
    // high throughout, so the enable changes only once at each end.
    task automatic configure(logic [3:0] id, logic [4:0] size,
                             logic [31:0] lt, logic [31:0] li);
        cfg_idx_t    idx[4];
        logic [31:0] val[4];
        idx = '{CFG_SERVER_ID, CFG_CLUSTER_SIZE, CFG_OWN_LAST_TERM, CFG_OWN_LAST_INDEX};
        val = '{{28'd0, id}, {27'd0, size}, lt, li};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Values next to a reference point, with an occasional wild one, so the
    // log and term comparisons land on both sides of equality.
    function automatic logic [31:0] near(logic [31:0] x);
        case ($urandom_range(0, 5))
            0:       return x + 1;
            1:       return x - 1;
            2:       return $urandom;
            default: return x;
        endcase
    endfunction

    // Random events steered by the mirrored state. A candidate mostly hears
    // responses to its own election so it can actually win; otherwise the mix
    // favors requests in the current or next term with logs near our own.
    // Fields that an event does not use carry random values.
    function automatic event_t make_event();
        event_t      ev;
        int          pick;
        logic [31:0] t;
        t  = sb.term;
        ev.operation           = OP_GET_STATE;
        ev.msg_term            = $urandom;
        ev.candidate_id        = 4'($urandom);
        ev.cand_last_log_term  = $urandom;
        ev.cand_last_log_index = $urandom;
        ev.election_term       = $urandom;
        ev.vote_yes            = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (sb.role == ROLE_CANDIDATE && pick < 65)
        begin
            ev.operation     = OP_RESPONSE;
            ev.msg_term      = (t >= 2) ? t - $urandom_range(0, 2) : t;
            ev.election_term = ($urandom_range(0, 9) == 0) ? t - 1 : t;
            ev.vote_yes      = ($urandom_range(0, 4) != 0);
        end
        else if (pick < 20)
            ev.operation = OP_TIMEOUT;
        else if (pick < 55)
        begin
            ev.operation           = OP_REQUEST;
            ev.msg_term            = ($urandom_range(0, 7) == 0) ? t - 1
                                                                 : t + $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0)
                ev.candidate_id = sb.voted[3:0];
            ev.cand_last_log_term  = near(sb.log_term);
            ev.cand_last_log_index = near(sb.log_index);
        end
        else if (pick < 70)
        begin
            ev.operation     = OP_RESPONSE;
            ev.msg_term      = ($urandom_range(0, 5) == 0) ? t + 1 : t;
            ev.election_term = near(t);
        end
        else if (pick < 80)
            ev.operation = OP_GET_STATE;
        else
        begin
            // Noise: any operation; only a few carry a fully random term so
            // the term does not run up to its ceiling early.
            ev.operation = op_t'($urandom_range(0, 3));
            if (pick < 97)
                ev.msg_term = near(t);
        end
        return ev;
    endfunction

    initial
    begin
        logic [4:0] size;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the register defaults: node 0 in a cluster of 3.
        post(OP_GET_STATE, '1, 4'hF, '1, '1, '1, 1'b1);   // state right after reset
        post(OP_TIMEOUT,   0, 0, 0, 0, 0, 1'b0);          // election for term 1
        post(OP_RESPONSE,  1, 0, 0, 0, 1, 1'b0);          // refusal, still candidate
        post(OP_RESPONSE,  1, 0, 0, 0, 1, 1'b1);          // second vote wins
        post(OP_TIMEOUT,   0, 0, 0, 0, 0, 1'b0);          // ignored while leader
        post(OP_REQUEST,   1, 5, 0, 0, 0, 1'b0);          // same term, already voted
        post(OP_REQUEST,   2, 5, 0, 0, 0, 1'b0);          // higher term, granted
        post(OP_REQUEST,   2, 5, 0, 0, 0, 1'b0);          // same candidate again
        post(OP_REQUEST,   2, 6, 0, 0, 0, 1'b0);          // other candidate refused
        post(OP_REQUEST,   3, 0, 0, 0, 0, 1'b0);          // candidate id equals ours
        post(OP_RESPONSE,  7, 0, 0, 0, 3, 1'b1);          // higher term in a response
        post(OP_RESPONSE,  4, 0, 0, 0, 7, 1'b1);          // stale while follower
        post(OP_TIMEOUT,   0, 0, 0, 0, 0, 1'b0);          // election for term 8
        post(OP_RESPONSE,  5, 0, 0, 0, 6, 1'b1);          // answers an older election
        post(OP_RESPONSE,  8, 0, 0, 0, 8, 1'b1);          // wins term 8
        post(OP_REQUEST,   0, 3, '1, '1, 0, 1'b0);        // lower term is ignored
        settle();

        // A log check against a non-empty own log, then random phases. The
        // register settings walk through the extremes: single node, a zero
        // cluster, the node limit and a value above it, full-scale logs.
        configure(4'd9, 5'd4, 32'd100, 32'd50);
        post(OP_REQUEST, 9, 2, 32'd99, '1, 0, 1'b0);       // older log term refused
        post(OP_REQUEST, 10, 2, 32'd100, 32'd49, 0, 1'b0); // shorter log refused
        post(OP_REQUEST, 10, 2, 32'd100, 32'd50, 0, 1'b0); // equal log granted
        post(OP_REQUEST, 11, 3, 32'd101, 32'd0, 0, 1'b0);  // newer log term granted
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       configure(4'd15, 5'd1, '0, '0);
                1:       configure(4'd0, 5'd0, '1, '1);
                2:       configure(4'($urandom), 5'd16, $urandom, $urandom);
                3:       configure(4'($urandom), 5'd31, $urandom, $urandom);
                4:       configure(4'($urandom), 5'd5, $urandom_range(0, 20),
                                   $urandom_range(0, 20));
                5:       configure(4'($urandom), 5'd2, $urandom, $urandom);
                6:       configure(4'($urandom), 5'd3, $urandom_range(0, 20), $urandom);
                default:
                begin
                    size = 5'($urandom_range(1, 16));
                    configure(4'($urandom), size, $urandom, $urandom);
                end
            endcase
            if (phase == 7)
            begin
                // The closing stretch runs with no idling on either side.
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end
            repeat (66) send_event(make_event());
            if (phase == 7)
            begin
                // Term at its ceiling: adopt the largest term, then time out
                // twice; the term must not wrap.
                post(OP_REQUEST, '1, 4'hF, '1, '1, 0, 1'b0);
                post(OP_TIMEOUT, 0, 0, 0, 0, 0, 1'b0);
                post(OP_TIMEOUT, 0, 0, 0, 0, 0, 1'b0);
            end
            settle();
        end

        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #400_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cle_pkg.sv
rtl/core/cle_event_reg.sv
rtl/core/cle_elect.sv
rtl/core/consensus_leader_election.sv
bench/tb.sv
